// ----- rtl/core/ctsd_pkg.sv -----
// ----------------------------------------------------------------------------
// ctsd_pkg
// shared types and constants for the clut texture stream decoder
// ----------------------------------------------------------------------------
package ctsd_pkg;

    localparam int unsigned PaletteDepthDefault = 256;
    localparam logic [31:0] TimMagic  = 32'(1 << 4);
    localparam int unsigned PalFlagBit = 3;
    localparam logic [2:0]  DepthMask = 3'((1 << 3) - 1);
    localparam logic [4:0]  FiveBits  = 5'h1F;
    localparam int unsigned AlphaBit  = 15;

    localparam logic [1:0] DEPTH_4  = 2'd0;
    localparam logic [1:0] DEPTH_8  = 2'd1;
    localparam logic [1:0] DEPTH_16 = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_of_file;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [17:0] pixel_x;
        logic [15:0] pixel_y;
        logic [17:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  depth_code;
        logic        status;
        logic        last_in_run;
        logic        last_pixel;
    } out_item_t;

    // classified work handed from the parser to the pixel back end
    typedef enum logic [1:0] {
        OP_ERROR = 2'd0,
        OP_PIX1  = 2'd1,
        OP_PIX2  = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        idx_a_ok;   // index a is palette looked up
        logic        direct;     // 16-bit colour, no lookup
        logic [15:0] colour_a;   // direct colour
        logic [7:0]  idx_a;
        logic [7:0]  idx_b;
        logic [17:0] x_a;
        logic [15:0] y_a;
        logic [17:0] x_b;
        logic [15:0] y_b;
        logic        last_a;
        logic        last_b;
        logic [17:0] width;
        logic [15:0] height;
        logic [1:0]  depth;
    } work_t;

    function automatic out_item_t expand(input logic [15:0] c, input work_t w,
                                         input logic second);
        out_item_t r;
        r.red          = {c[14:10], 3'b000};
        r.green        = {c[9:5], 3'b000};
        r.blue         = {c[4:0], 3'b000};
        r.alpha        = c[AlphaBit] ? 8'd0 : 8'd255;
        r.pixel_x      = second ? w.x_b : w.x_a;
        r.pixel_y      = second ? w.y_b : w.y_a;
        r.image_width  = w.width;
        r.image_height = w.height;
        r.depth_code   = w.depth;
        r.status       = 1'b0;
        r.last_in_run  = 1'b0;
        r.last_pixel   = second ? w.last_b : w.last_a;
        return r;
    endfunction

endpackage

// ----- rtl/core/ctsd_stream_if.sv -----
// ----------------------------------------------------------------------------
// ctsd_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface ctsd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ctsd_parser.sv -----
// ----------------------------------------------------------------------------
// ctsd_parser
// front end: header parsing, palette loading and pixel classification
// ----------------------------------------------------------------------------
module ctsd_parser #(
    parameter int unsigned PALETTE_DEPTH = ctsd_pkg::PaletteDepthDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ctsd_pkg::in_item_t    in_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    input  logic                  q_idle,
    output ctsd_pkg::work_t       q_data,
    output logic                  pal_we,
    output logic [7:0]            pal_waddr,
    output logic [15:0]           pal_wdata,
    output logic                  pal_clear
);
    typedef enum logic [3:0] {
        PH_IDLE, PH_MAGIC, PH_FLAGS, PH_CLUT_SIZE, PH_CLUT_POS, PH_CLUT_DIM,
        PH_CLUT_DATA, PH_IMG_SIZE, PH_IMG_POS, PH_IMG_DIM, PH_PIXELS, PH_DONE
    } phase_t;

    phase_t      phase_reg;
    logic [1:0]  bif_reg;
    logic [23:0] field_reg;
    logic [1:0]  depth_reg;
    logic [31:0] left_reg;
    logic [8:0]  widx_reg;
    logic [17:0] width_reg;
    logic [15:0] height_reg;
    logic [17:0] col_reg;
    logic [15:0] row_reg;
    logic [7:0]  low_reg;

    logic        take;
    phase_t      ph;
    logic [1:0]  bif;
    logic [31:0] word;
    logic [15:0] wdim;
    logic [31:0] prod;
    logic [17:0] wcalc;
    logic        col_end_a;
    logic        row_end_a;
    logic [17:0] col_a1;
    logic [15:0] row_a1;

    // a start waits until queued pixel requests have read the old palette
    assign in_ready = q_ready && (q_idle || !in_data.start_of_file);
    assign take     = in_valid && in_ready;
    assign ph       = in_data.start_of_file ? PH_MAGIC : phase_reg;
    assign bif      = in_data.start_of_file ? 2'd0 : bif_reg;
    assign word     = {in_data.data_byte, field_reg};
    assign wdim     = word[15:0];
    assign prod     = 32'(word[15:0]) * 32'(word[31:16]);
    always_comb
    begin
        unique case (depth_reg)
            ctsd_pkg::DEPTH_4:  wcalc = {wdim, 2'b00};
            ctsd_pkg::DEPTH_8:  wcalc = {1'b0, wdim, 1'b0};
            default:            wcalc = {2'b00, wdim};
        endcase
    end
    assign col_a1    = col_reg + 18'd1;
    assign row_a1    = row_reg + 16'd1;
    assign col_end_a = (col_a1 >= width_reg);
    assign row_end_a = (row_a1 >= height_reg);

    always_comb
    begin
        q_valid = 1'b0;
        q_data  = '0;
        q_data.op     = ctsd_pkg::OP_ERROR;
        q_data.idx_a  = in_data.data_byte;
        q_data.idx_b  = {4'd0, in_data.data_byte[7:4]};
        q_data.x_a    = col_reg;
        q_data.y_a    = row_reg;
        q_data.x_b    = col_end_a ? 18'd0 : col_a1;
        q_data.y_b    = row_reg;
        q_data.last_a = col_end_a && row_end_a;
        q_data.last_b = (col_a1 + 18'd1 == width_reg) && row_end_a;
        q_data.width  = width_reg;
        q_data.height = height_reg;
        q_data.depth  = depth_reg;
        q_data.colour_a = {in_data.data_byte, low_reg};
        pal_we    = 1'b0;
        pal_waddr = widx_reg[7:0];
        pal_wdata = {in_data.data_byte, low_reg};
        pal_clear = take && in_data.start_of_file;
        if (in_valid)
        begin
            if (ph == PH_MAGIC && bif == 2'd3 && word != ctsd_pkg::TimMagic)
            begin
                q_valid = 1'b1;
            end
            else if (ph == PH_PIXELS)
            begin
                if (depth_reg == ctsd_pkg::DEPTH_4)
                begin
                    q_valid = 1'b1;
                    q_data.op = col_end_a ? ctsd_pkg::OP_PIX1 : ctsd_pkg::OP_PIX2;
                    q_data.idx_a = {4'd0, in_data.data_byte[3:0]};
                    q_data.idx_a_ok = 1'b1;
                end
                else if (depth_reg == ctsd_pkg::DEPTH_8)
                begin
                    q_valid = 1'b1;
                    q_data.op = ctsd_pkg::OP_PIX1;
                    q_data.idx_a_ok = 1'b1;
                end
                else if (bif_reg == 2'd1)
                begin
                    q_valid = 1'b1;
                    q_data.op = ctsd_pkg::OP_PIX1;
                    q_data.direct = 1'b1;
                end
            end
            else if (ph == PH_CLUT_DATA && bif_reg == 2'd1
                     && widx_reg < 9'(PALETTE_DEPTH))
            begin
                pal_we = take;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bif_reg    <= '0;
            field_reg  <= '0;
            depth_reg  <= '0;
            left_reg   <= '0;
            widx_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            low_reg    <= '0;
        end
        else if (take)
        begin
            if (in_data.start_of_file)
            begin
                phase_reg  <= PH_MAGIC;
                depth_reg  <= '0;
                left_reg   <= '0;
                widx_reg   <= '0;
                width_reg  <= '0;
                height_reg <= '0;
                col_reg    <= '0;
                row_reg    <= '0;
                low_reg    <= '0;
            end
            unique case (ph)
                PH_MAGIC, PH_FLAGS, PH_CLUT_SIZE, PH_CLUT_POS, PH_CLUT_DIM,
                PH_IMG_SIZE, PH_IMG_POS, PH_IMG_DIM:
                begin
                    // little-endian field assembly, byte at bif
                    unique case (bif)
                        2'd0: field_reg <= {16'd0, in_data.data_byte};
                        2'd1: field_reg[15:8] <= in_data.data_byte;
                        2'd2: field_reg[23:16] <= in_data.data_byte;
                        default: field_reg <= field_reg;
                    endcase
                    bif_reg <= bif + 2'd1;
                    if (bif == 2'd3)
                    begin
                        bif_reg <= 2'd0;
                        unique case (ph)
                            PH_MAGIC:
                                phase_reg <= (word == ctsd_pkg::TimMagic) ? PH_FLAGS
                                                                          : PH_IDLE;
                            PH_FLAGS:
                            begin
                                depth_reg <= ((word[2:0] & ctsd_pkg::DepthMask) <= 3'd2)
                                             ? word[1:0] : 2'd0;
                                phase_reg <= word[ctsd_pkg::PalFlagBit] ? PH_CLUT_SIZE
                                                                        : PH_IMG_SIZE;
                            end
                            PH_CLUT_SIZE: phase_reg <= PH_CLUT_POS;
                            PH_CLUT_POS:  phase_reg <= PH_CLUT_DIM;
                            PH_CLUT_DIM:
                            begin
                                left_reg  <= prod;
                                widx_reg  <= '0;
                                phase_reg <= (prod != 32'd0) ? PH_CLUT_DATA : PH_IMG_SIZE;
                            end
                            PH_IMG_SIZE:  phase_reg <= PH_IMG_POS;
                            PH_IMG_POS:   phase_reg <= PH_IMG_DIM;
                            default:
                            begin
                                width_reg  <= wcalc;
                                height_reg <= word[31:16];
                                col_reg    <= '0;
                                row_reg    <= '0;
                                phase_reg  <= (wcalc == 18'd0 || word[31:16] == 16'd0)
                                              ? PH_DONE : PH_PIXELS;
                            end
                        endcase
                    end
                end
                PH_CLUT_DATA:
                begin
                    if (bif_reg == 2'd0)
                    begin
                        low_reg <= in_data.data_byte;
                        bif_reg <= 2'd1;
                    end
                    else
                    begin
                        if (widx_reg < 9'(PALETTE_DEPTH))
                            widx_reg <= widx_reg + 9'd1;
                        bif_reg  <= 2'd0;
                        left_reg <= left_reg - 32'd1;
                        if (left_reg == 32'd1)
                        begin
                            phase_reg <= PH_IMG_SIZE;
                            field_reg <= '0;
                        end
                    end
                end
                PH_PIXELS:
                begin
                    if (depth_reg == ctsd_pkg::DEPTH_16 && bif_reg == 2'd0)
                    begin
                        low_reg <= in_data.data_byte;
                        bif_reg <= 2'd1;
                    end
                    else
                    begin
                        bif_reg <= 2'd0;
                        if (depth_reg == ctsd_pkg::DEPTH_4 && !col_end_a)
                        begin
                            // two pixels from one byte
                            if (col_a1 + 18'd1 >= width_reg)
                            begin
                                col_reg <= '0;
                                row_reg <= row_a1;
                                if (row_end_a)
                                    phase_reg <= PH_DONE;
                            end
                            else
                            begin
                                col_reg <= col_a1 + 18'd1;
                            end
                        end
                        else if (col_end_a)
                        begin
                            col_reg <= '0;
                            row_reg <= row_a1;
                            if (row_end_a)
                                phase_reg <= PH_DONE;
                        end
                        else
                        begin
                            col_reg <= col_a1;
                        end
                    end
                end
                default: phase_reg <= phase_reg;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pal_we |-> (phase_reg == PH_CLUT_DATA))
        else $error("palette write outside palette phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> (width_reg != 18'd0 && height_reg != 16'd0))
        else $error("pixel phase with empty image");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> (col_reg < width_reg && row_reg < height_reg))
        else $error("pixel position out of image");
endmodule

// ----- rtl/core/ctsd_queue.sv -----
// ----------------------------------------------------------------------------
// ctsd_queue
// two-entry queue between the parser and the pixel back end
// ----------------------------------------------------------------------------
module ctsd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ctsd_pkg::work_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ctsd_pkg::work_t out_data
);
    ctsd_pkg::work_t mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue push not counted");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
endmodule

// ----- rtl/core/ctsd_pixel_unit.sv -----
// ----------------------------------------------------------------------------
// ctsd_pixel_unit
// back end: palette store, colour lookup, expansion and result sequencing
// ----------------------------------------------------------------------------
module ctsd_pixel_unit #(
    parameter int unsigned PALETTE_DEPTH = ctsd_pkg::PaletteDepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              w_valid,
    output logic              w_ready,
    input  ctsd_pkg::work_t   w_data,
    input  logic              pal_we,
    input  logic [7:0]        pal_waddr,
    input  logic [15:0]       pal_wdata,
    input  logic              pal_clear,
    output logic              out_valid,
    input  logic              out_ready,
    output ctsd_pkg::out_item_t out_data
);
    typedef enum logic [1:0] {
        S_EMPTY, S_ONE, S_FIRST, S_SECOND
    } st_t;

    logic [15:0]              pal_mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] valid_reg;
    st_t                      st_reg;
    ctsd_pkg::work_t          w_reg;
    logic [15:0]              ca_reg;
    logic [15:0]              cb_reg;
    logic                     load;
    logic                     done;

    function automatic logic [15:0] look(input logic [7:0] idx,
                                         input logic [PALETTE_DEPTH-1:0] v,
                                         input logic [15:0] d);
        logic hit;
        hit = (32'(idx) < PALETTE_DEPTH) && v[idx];
        return hit ? d : 16'd0;
    endfunction

    assign done = out_ready || (st_reg == S_EMPTY);
    assign load = w_valid && w_ready;
    assign w_ready = (st_reg == S_EMPTY) || (out_ready && st_reg != S_FIRST);

    // both palette reads land in registers as the request is loaded
    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[pal_waddr] <= pal_wdata;
        if (load)
        begin
            w_reg  <= w_data;
            ca_reg <= w_data.direct ? w_data.colour_a
                    : look(w_data.idx_a, valid_reg, pal_mem[w_data.idx_a]);
            cb_reg <= look(w_data.idx_b, valid_reg, pal_mem[w_data.idx_b]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            st_reg    <= S_EMPTY;
        end
        else
        begin
            if (pal_clear)
                valid_reg <= '0;
            else if (pal_we)
                valid_reg[pal_waddr] <= 1'b1;
            if (load)
                st_reg <= (w_data.op == ctsd_pkg::OP_PIX2) ? S_FIRST : S_ONE;
            else if (done)
                st_reg <= (st_reg == S_FIRST) ? S_SECOND : S_EMPTY;
        end
    end

    always_comb
    begin
        out_valid = (st_reg != S_EMPTY);
        if (w_reg.op == ctsd_pkg::OP_ERROR)
        begin
            out_data = '0;
            out_data.status = 1'b1;
            out_data.last_in_run = 1'b1;
        end
        else if (st_reg == S_SECOND)
        begin
            out_data = ctsd_pkg::expand(cb_reg, w_reg, 1'b1);
            out_data.last_in_run = 1'b1;
        end
        else
        begin
            out_data = ctsd_pkg::expand(ca_reg, w_reg, 1'b0);
            out_data.last_in_run = (st_reg != S_FIRST);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_FIRST && out_ready) |=> (st_reg == S_SECOND))
        else $error("second pixel lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (st_reg == $past(st_reg)))
        else $error("result changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_FIRST) |-> !w_ready)
        else $error("accepted work while pair pending");
endmodule

// ----- rtl/core/clut_texture_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// clut_texture_stream_decoder_unit
// byte-stream texture decoder with palette lookup
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one file byte per request with start_of_file marking the
//   first magic byte. out_ch carries decoded pixels (or one bad magic error).
//   one byte is taken per cycle while the queue has room and no start waits;
//   a pixel leaves after its last byte passes one queue stage and one
//   lookup/output register. a 4 bpp byte gives two results, and the output
//   register holds such a two-pixel request until both go, so that mode
//   backs up into the queue; unstalled, other modes take one byte per cycle.
//   palette bytes and header bytes produce no result.
//   a start_of_file request is held until the queue is empty, so earlier
//   pixels still see the palette of their own file.
//   reset puts the parser in its wait-for-start phase and marks every
//   palette entry unloaded; no clearing pass is needed.
//   when out_ch stalls, the two-entry queue fills and then in_ch ready drops;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module clut_texture_stream_decoder_unit #(
    parameter int unsigned PALETTE_DEPTH = ctsd_pkg::PaletteDepthDefault
) (
    input logic clk,
    input logic rst_n,
    ctsd_stream_if.sink   in_ch,
    ctsd_stream_if.source out_ch
);
    logic            f_valid;
    logic            f_ready;
    ctsd_pkg::work_t f_data;
    logic            b_valid;
    logic            b_ready;
    ctsd_pkg::work_t b_data;
    logic            q_idle;
    logic            pal_we;
    logic [7:0]      pal_waddr;
    logic [15:0]     pal_wdata;
    logic            pal_clear;

    assign q_idle = !b_valid;

    ctsd_parser #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_parser (
        .clk, .rst_n,
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_data  (in_ch.data),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_idle   (q_idle),
        .q_data   (f_data),
        .pal_we, .pal_waddr, .pal_wdata, .pal_clear
    );

    ctsd_queue u_queue (
        .clk, .rst_n,
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    ctsd_pixel_unit #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_pixel (
        .clk, .rst_n,
        .w_valid   (b_valid),
        .w_ready   (b_ready),
        .w_data    (b_data),
        .pal_we, .pal_waddr, .pal_wdata, .pal_clear,
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives texture byte streams into the clut texture stream decoder and checks
// every decoded pixel and bad magic error against an in-bench decoder model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned PalDepth = 256;
    localparam int unsigned CycleLimit = 1500000;

    // parser phases of the prediction model
    typedef enum int {
        P_IDLE, P_MAGIC, P_FLAGS, P_CLUT_SIZE, P_CLUT_POS, P_CLUT_DIM,
        P_CLUT_DATA, P_IMG_SIZE, P_IMG_POS, P_IMG_DIM, P_PIXELS, P_DONE
    } phase_t;

    logic clk;
    logic rst_n;

    ctsd_stream_if #(.payload_t(ctsd_pkg::in_item_t))  in_ch ();
    ctsd_stream_if #(.payload_t(ctsd_pkg::out_item_t)) out_ch ();

    clut_texture_stream_decoder_unit #(.PALETTE_DEPTH(PalDepth)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // decoder model state
    phase_t      phase;
    int unsigned field_byte;
    logic [31:0] field_word;
    logic [1:0]  cur_depth;
    logic [31:0] clut_left;
    int unsigned clut_wr;
    logic [15:0] clut_mem [PalDepth];
    logic        clut_ok  [PalDepth];
    logic [17:0] img_w;
    logic [15:0] img_h;
    logic [17:0] col;
    logic [15:0] row;
    logic [7:0]  lo_byte;

    ctsd_pkg::out_item_t pixels_due [$];
    int unsigned mismatches;
    bit          idle_on;
    int unsigned cycles;
    int unsigned stall_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void model_restart();
        phase = P_MAGIC;
        field_byte = 0;
        field_word = '0;
        cur_depth = ctsd_pkg::DEPTH_4;
        clut_left = '0;
        clut_wr = 0;
        img_w = '0;
        img_h = '0;
        col = '0;
        row = '0;
        lo_byte = '0;
        for (int i = 0; i < PalDepth; i++)
            clut_ok[i] = 1'b0;
    endfunction

    function automatic void next_field(phase_t p);
        phase = p;
        field_byte = 0;
        field_word = '0;
    endfunction

    function automatic bit gather(logic [7:0] b);
        field_word |= 32'(b) << (8 * field_byte);
        if (field_byte == 3)
            return 1'b1;
        field_byte++;
        return 1'b0;
    endfunction

    function automatic logic [15:0] lookup(int unsigned idx);
        if (idx < PalDepth && clut_ok[idx])
            return clut_mem[idx];
        return 16'h0;
    endfunction

    // queue one pixel, returns 1 when it ended a row
    function automatic bit push_pixel(logic [15:0] c);
        ctsd_pkg::out_item_t r;
        r.red          = {c[14:10], 3'b000};
        r.green        = {c[9:5], 3'b000};
        r.blue         = {c[4:0], 3'b000};
        r.alpha        = c[15] ? 8'd0 : 8'd255;
        r.pixel_x      = col;
        r.pixel_y      = row;
        r.image_width  = img_w;
        r.image_height = img_h;
        r.depth_code   = cur_depth;
        r.status       = 1'b0;
        r.last_in_run  = 1'b0;
        r.last_pixel   = (32'(col) + 1 == 32'(img_w)) && (32'(row) + 1 == 32'(img_h));
        pixels_due.push_back(r);
        col++;
        if (col >= img_w)
        begin
            col = '0;
            row++;
            if (row >= img_h)
                phase = P_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic sof);
        int unsigned n0;
        ctsd_pkg::out_item_t e;
        logic [31:0] w;
        n0 = pixels_due.size();
        if (sof)
            model_restart();
        case (phase)
            P_MAGIC:
                if (gather(b))
                begin
                    if (field_word != ctsd_pkg::TimMagic)
                    begin
                        e = '0;
                        e.status = 1'b1;
                        pixels_due.push_back(e);
                        phase = P_IDLE;
                    end
                    else
                        next_field(P_FLAGS);
                end
            P_FLAGS:
                if (gather(b))
                begin
                    cur_depth = (field_word[2:0] <= 3'd2) ? field_word[1:0]
                                                          : ctsd_pkg::DEPTH_4;
                    next_field(field_word[ctsd_pkg::PalFlagBit] ? P_CLUT_SIZE : P_IMG_SIZE);
                end
            P_CLUT_SIZE: if (gather(b)) next_field(P_CLUT_POS);
            P_CLUT_POS:  if (gather(b)) next_field(P_CLUT_DIM);
            P_CLUT_DIM:
                if (gather(b))
                begin
                    clut_left = field_word[15:0] * field_word[31:16];
                    clut_wr = 0;
                    next_field(clut_left != 0 ? P_CLUT_DATA : P_IMG_SIZE);
                end
            P_CLUT_DATA:
                if (field_byte == 0)
                begin
                    lo_byte = b;
                    field_byte = 1;
                end
                else
                begin
                    if (clut_wr < PalDepth)
                    begin
                        clut_mem[clut_wr] = {b, lo_byte};
                        clut_ok[clut_wr] = 1'b1;
                        clut_wr++;
                    end
                    field_byte = 0;
                    clut_left--;
                    if (clut_left == 0)
                        next_field(P_IMG_SIZE);
                end
            P_IMG_SIZE: if (gather(b)) next_field(P_IMG_POS);
            P_IMG_POS:  if (gather(b)) next_field(P_IMG_DIM);
            P_IMG_DIM:
                if (gather(b))
                begin
                    w = field_word[15:0] * (cur_depth == ctsd_pkg::DEPTH_4 ? 4 :
                                            cur_depth == ctsd_pkg::DEPTH_8 ? 2 : 1);
                    img_w = w[17:0];
                    img_h = field_word[31:16];
                    col = '0;
                    row = '0;
                    field_byte = 0;
                    phase = (img_w == 0 || img_h == 0) ? P_DONE : P_PIXELS;
                end
            P_PIXELS:
                if (cur_depth == ctsd_pkg::DEPTH_4)
                begin
                    if (!push_pixel(lookup(32'(b[3:0]))))
                        void'(push_pixel(lookup(32'(b[7:4]))));
                end
                else if (cur_depth == ctsd_pkg::DEPTH_8)
                    void'(push_pixel(lookup(32'(b))));
                else if (field_byte == 0)
                begin
                    lo_byte = b;
                    field_byte = 1;
                end
                else
                begin
                    field_byte = 0;
                    void'(push_pixel({b, lo_byte}));
                end
            default: ;
        endcase
        if (pixels_due.size() > n0)
            pixels_due[pixels_due.size() - 1].last_in_run = 1'b1;
    endfunction

    // input side: sends one byte, model updated when it is accepted
    task automatic send_byte(logic [7:0] b, logic sof);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{data_byte: b, start_of_file: sof};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        decode_byte(b, sof);
    endtask

    task automatic send_word(logic [31:0] w, bit sof_first);
        for (int i = 0; i < 4; i++)
            send_byte(w[8*i +: 8], sof_first && i == 0);
    endtask

    // sends a whole file: header, optional palette, image header, pixel bytes
    task automatic send_file(logic [31:0] flags, int unsigned pw, int unsigned ph,
                             logic [15:0] iw, logic [15:0] ih, int unsigned nbytes);
        logic [15:0] c;
        send_word(ctsd_pkg::TimMagic, 1'b1);
        send_word(flags, 1'b0);
        if (flags[ctsd_pkg::PalFlagBit])
        begin
            send_word($urandom, 1'b0);
            send_word($urandom, 1'b0);
            send_word({16'(ph), 16'(pw)}, 1'b0);
            for (int i = 0; i < pw * ph; i++)
            begin
                c = 16'($urandom);
                send_byte(c[7:0], 1'b0);
                send_byte(c[15:8], 1'b0);
            end
        end
        send_word($urandom, 1'b0);
        send_word($urandom, 1'b0);
        send_word({ih, iw}, 1'b0);
        for (int i = 0; i < nbytes; i++)
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // output side: random stalls and field-by-field compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", out_ch.data);
                end
                else if (pixels_due[0] !== out_ch.data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p got %p", pixels_due[0], out_ch.data);
                    void'(pixels_due.pop_front());
                end
                else
                    void'(pixels_due.pop_front());
            end
            if (stall_left != 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                // start a stall burst
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic test_bad_magic();
        send_word(32'h11, 1'b1);
        send_word(32'h10, 1'b0);  // ignored after the error
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        drain();
    endtask

    task automatic test_directed_files();
        // no palette, 16 bpp, trailing bytes ignored
        send_file(32'h2, 0, 0, 16'd2, 16'd1, 6);
        // 4 bpp, empty palette
        send_file(32'h8, 0, 0, 16'd1, 16'd2, 3);
        // 8 bpp with small palette, unloaded indices read zero
        send_file(32'h9, 4, 1, 16'd2, 16'd2, 8);
        // depth codes beyond 16 bpp fall back to 4 bpp
        send_file(32'hF, 2, 1, 16'd1, 16'd1, 2);
        // empty image
        send_file(32'h1, 0, 0, 16'd0, 16'd3, 3);
        // restart in mid file
        send_word(ctsd_pkg::TimMagic, 1'b1);
        send_byte(8'h09, 1'b0);
        drain();
    endtask

    task automatic test_palette_overflow();
        // one entry more than the store holds
        send_file(32'h9, 257, 1, 16'd2, 16'd1, 4);
        drain();
    endtask

    task automatic test_random_files(int unsigned budget);
        int unsigned mode;
        int unsigned pw;
        int unsigned nb;
        int unsigned sent;
        logic [31:0] flags;
        logic [15:0] iw;
        logic [15:0] ih;
        sent = 0;
        while (sent < budget)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                pw = $urandom_range(0, 20);
                iw = 16'($urandom_range(0, 4));
                ih = 16'($urandom_range(0, 4));
                nb = $urandom_range(0, 40);
                flags = ($urandom_range(0, 1) != 0 ? 32'hFFFF_FFF0 : 32'h0)
                        | 32'($urandom_range(0, 15));
                send_file(flags, pw, 1, iw, ih, nb);
                sent += 20 + nb;
                if (flags[ctsd_pkg::PalFlagBit])
                    sent += 12 + 2 * pw;
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        stall_left = 0;
        idle_on = 1'b1;
        phase = P_IDLE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_byte(8'h10, 1'b0);  // ignored before any start
        test_bad_magic();
        test_directed_files();
        test_palette_overflow();
        test_random_files(40);
        idle_on = 1'b0;
        test_random_files(40);
        if (mismatches == 0 && pixels_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
